[rtl/core/pss_pkg.sv]
// ----------------------------------------------------------------------------
// pss_pkg: shared constants and types for the periodic sphere selector
// register map codes and the widths fixed by the register file
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

   // radius_sq register width, fixed by the register map
   localparam int unsigned RSQ_BITS = 47;

   // configuration port geometry: 64-bit data, registers on 8-byte spacing
   localparam int unsigned CSR_DATA_BITS = 64;
   localparam int unsigned CSR_ADDR_BITS = 6;
   localparam int unsigned CSR_INDEX_LSB = 3;
   localparam int unsigned CSR_INDEX_BITS = CSR_ADDR_BITS - CSR_INDEX_LSB;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CENTER_X     = 3'd0,
      REG_CENTER_Y     = 3'd1,
      REG_CENTER_Z     = 3'd2,
      REG_RADIUS_SQ    = 3'd3,
      REG_BOX_LEN      = 3'd4,
      REG_MAX_SELECTED = 3'd5
   } csr_reg_type;

endpackage

`default_nettype wire

[rtl/core/pss_ifs.sv]
// ----------------------------------------------------------------------------
// pss_ifs: valid/ready channel interfaces of the periodic sphere selector
// particle position channel and selection result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface pss_req_if #(
   parameter int unsigned COORD_BITS = 24
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;
   logic [COORD_BITS-1:0] pos_z;
   logic                  last;

   modport source (output valid, output pos_x, output pos_y, output pos_z, output last,
                   input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, input last,
                   output ready);
endinterface

interface pss_rsp_if #(
   parameter int unsigned COORD_BITS = 24
);
   logic                  valid;
   logic                  ready;
   logic                  keep;
   logic [COORD_BITS-1:0] slot;
   logic [COORD_BITS-1:0] out_x;
   logic [COORD_BITS-1:0] out_y;
   logic [COORD_BITS-1:0] out_z;
   logic                  overflow;
   logic                  end_of_set;

   modport source (output valid, output keep, output slot, output out_x, output out_y,
                   output out_z, output overflow, output end_of_set, input ready);
   modport sink   (input valid, input keep, input slot, input out_x, input out_y,
                   input out_z, input overflow, input end_of_set, output ready);
endinterface

`default_nettype wire

[rtl/core/pss_axis.sv]
// ----------------------------------------------------------------------------
// pss_axis: one axis of the periodic distance
// absolute difference, pipelined restoring remainder by the box length,
// nearest-image fold with round half to even, and square
// ----------------------------------------------------------------------------
`default_nettype none

module pss_axis #(
   parameter int unsigned COORD_BITS = 24
) (
   input  wire logic                    clock,
   input  wire logic                    enable,
   input  wire logic [COORD_BITS-1:0]   pos,
   input  wire logic [COORD_BITS-1:0]   center,
   input  wire logic [COORD_BITS:0]     box_len,
   output logic      [2*COORD_BITS-1:0] sq_out
);

   localparam int unsigned CB = COORD_BITS;

   logic [CB-1:0]   mag_ff;
   logic [CB-1:0]   mag_in;
   logic [CB-1:0]   rem_ff [CB];
   logic [CB-1:0]   dvd_ff [CB-1];
   logic            qlsb_ff;
   logic [CB-1:0]   wrap_ff;
   logic [CB-1:0]   wrap_in;
   logic [2*CB-1:0] sq_ff;
   logic [2*CB-1:0] sq_in;

   // distance magnitude; the sign vanishes in the square
   assign mag_in = (pos >= center) ? (pos - center) : (center - pos);

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff <= mag_in;
      end
   end

   // one quotient bit per stage, msb first; a zero length leaves the
   // remainder equal to the dividend
   for (genvar s = 0; s < CB; s++) begin : g_div
      logic [CB-1:0] rem_prev;
      logic [CB-1:0] dvd_prev;
      logic [CB:0]   trial;
      logic [CB:0]   diff;
      logic          fits;
      logic [CB-1:0] rem_in;

      if (s == 0) begin : g_first
         assign rem_prev = '0;
         assign dvd_prev = mag_ff;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign dvd_prev = dvd_ff[s-1];
      end

      assign trial  = {rem_prev, dvd_prev[CB-1-s]};
      assign fits   = (trial >= box_len);
      assign diff   = trial - box_len;
      assign rem_in = fits ? diff[CB-1:0] : trial[CB-1:0];

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= rem_in;
         end
      end

      if (s < CB - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               dvd_ff[s] <= dvd_prev;
            end
         end
      end else begin : g_qlsb
         always_ff @(posedge clock) begin
            if (enable) begin
               qlsb_ff <= fits;
            end
         end
      end
   end

   // fold to the nearest image; an exact half folds only on an odd quotient
   logic [CB-1:0] rem_last;
   logic [CB:0]   twice;
   logic [CB:0]   flip;
   logic          fold;

   assign rem_last = rem_ff[CB-1];
   assign twice    = {rem_last, 1'b0};
   assign flip     = box_len - {1'b0, rem_last};
   assign fold     = (box_len != '0) &&
                     ((twice > box_len) || ((twice == box_len) && qlsb_ff));
   assign wrap_in  = fold ? flip[CB-1:0] : rem_last;

   always_ff @(posedge clock) begin
      if (enable) begin
         wrap_ff <= wrap_in;
      end
   end

   assign sq_in = {{CB{1'b0}}, wrap_ff} * {{CB{1'b0}}, wrap_ff};

   always_ff @(posedge clock) begin
      if (enable) begin
         sq_ff <= sq_in;
      end
   end

   assign sq_out = sq_ff;

endmodule

`default_nettype wire

[rtl/core/periodic_sphere_particle_selector.sv]
// ----------------------------------------------------------------------------
// periodic_sphere_particle_selector: minimum-image sphere selection
// streams particle positions and keeps those inside a periodic sphere
// ----------------------------------------------------------------------------
// One transaction is accepted per clock cycle while req.ready is high, and
// each produces exactly one result transaction. Each passes the difference
// stage, the per-axis remainder pipeline, which retires one quotient bit
// per stage (COORD_BITS stages), and the fold, square, sum/compare and
// output stages. A two-entry output buffer (result register plus skid
// register) lets req keep flowing while one result waits on rsp; req.ready
// drops only once both are full. The user must write centre, radius, box
// length and capacity through the csr port only while no transaction is in
// flight; the block itself does not enforce this. The selected count clears
// after the transaction marked last, also when that transaction overflowed.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_sphere_particle_selector #(
   parameter int unsigned COORD_BITS = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   pss_req_if.sink                                  req,
   pss_rsp_if.source                                rsp,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [pss_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [pss_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [pss_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                     csr_pready
);

   import pss_pkg::*;

   localparam int unsigned CB        = COORD_BITS;
   // difference, remainder stages, fold, square
   localparam int unsigned AXIS_LAT  = CB + 3;
   // plus the sum and compare stage
   localparam int unsigned PIPE      = AXIS_LAT + 1;
   localparam int unsigned DIST_BITS = 2 * CB + 2;
   localparam int unsigned CMP_BITS  = (DIST_BITS > RSQ_BITS) ? DIST_BITS : RSQ_BITS;
   localparam logic [CB:0] FULL_CAP  = {1'b1, {CB{1'b0}}};

   typedef struct packed {
      logic          keep;
      logic [CB-1:0] slot;
      logic [CB-1:0] out_x;
      logic [CB-1:0] out_y;
      logic [CB-1:0] out_z;
      logic          overflow;
      logic          end_of_set;
   } result_type;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [CB-1:0]       center_x_ff;
   logic [CB-1:0]       center_y_ff;
   logic [CB-1:0]       center_z_ff;
   logic [RSQ_BITS-1:0] radius_sq_ff;
   logic [CB:0]         box_len_ff;
   logic [CB:0]         max_sel_ff;
   logic                csr_write;
   csr_reg_type         csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_reg_type'(csr_paddr[CSR_ADDR_BITS-1:CSR_INDEX_LSB]);

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         center_z_ff  <= '0;
         radius_sq_ff <= '0;
         box_len_ff   <= FULL_CAP;
         max_sel_ff   <= FULL_CAP;
      end else if (csr_write) begin
         case (csr_index)
            REG_CENTER_X:     center_x_ff  <= csr_pwdata[CB-1:0];
            REG_CENTER_Y:     center_y_ff  <= csr_pwdata[CB-1:0];
            REG_CENTER_Z:     center_z_ff  <= csr_pwdata[CB-1:0];
            REG_RADIUS_SQ:    radius_sq_ff <= csr_pwdata[RSQ_BITS-1:0];
            REG_BOX_LEN:      box_len_ff   <= csr_pwdata[CB:0];
            REG_MAX_SELECTED: max_sel_ff   <= csr_pwdata[CB:0];
            default: ;   // addresses past the map are ignored
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CENTER_X:     csr_prdata = CSR_DATA_BITS'(center_x_ff);
         REG_CENTER_Y:     csr_prdata = CSR_DATA_BITS'(center_y_ff);
         REG_CENTER_Z:     csr_prdata = CSR_DATA_BITS'(center_z_ff);
         REG_RADIUS_SQ:    csr_prdata = CSR_DATA_BITS'(radius_sq_ff);
         REG_BOX_LEN:      csr_prdata = CSR_DATA_BITS'(box_len_ff);
         REG_MAX_SELECTED: csr_prdata = CSR_DATA_BITS'(max_sel_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // pipeline advance: the whole pipe moves unless the skid register is
   // occupied, so ready is a plain flop output
   // ------------------------------------------------------------------
   logic skid_vld_ff;
   logic enable;

   assign enable    = !skid_vld_ff;
   assign req.ready = enable;

   // ------------------------------------------------------------------
   // per-axis distance squares
   // ------------------------------------------------------------------
   logic [2*CB-1:0] sq_x;
   logic [2*CB-1:0] sq_y;
   logic [2*CB-1:0] sq_z;

   pss_axis #(.COORD_BITS(CB)) u_axis_x (
      .clock   (clock),
      .enable  (enable),
      .pos     (req.pos_x),
      .center  (center_x_ff),
      .box_len (box_len_ff),
      .sq_out  (sq_x)
   );

   pss_axis #(.COORD_BITS(CB)) u_axis_y (
      .clock   (clock),
      .enable  (enable),
      .pos     (req.pos_y),
      .center  (center_y_ff),
      .box_len (box_len_ff),
      .sq_out  (sq_y)
   );

   pss_axis #(.COORD_BITS(CB)) u_axis_z (
      .clock   (clock),
      .enable  (enable),
      .pos     (req.pos_z),
      .center  (center_z_ff),
      .box_len (box_len_ff),
      .sq_out  (sq_z)
   );

   // ------------------------------------------------------------------
   // side band delay line: valid, last and the coordinates travel with
   // the arithmetic so they line up with the compare result
   // ------------------------------------------------------------------
   logic [PIPE-1:0] vld_ff;
   logic [PIPE-1:0] last_ff;
   logic [CB-1:0]   px_ff [PIPE];
   logic [CB-1:0]   py_ff [PIPE];
   logic [CB-1:0]   pz_ff [PIPE];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[PIPE-2:0], req.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         last_ff  <= {last_ff[PIPE-2:0], req.last};
         px_ff[0] <= req.pos_x;
         py_ff[0] <= req.pos_y;
         pz_ff[0] <= req.pos_z;
         for (int i = 1; i < PIPE; i++) begin
            px_ff[i] <= px_ff[i-1];
            py_ff[i] <= py_ff[i-1];
            pz_ff[i] <= pz_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // sum of squares and strict compare against radius_sq
   // ------------------------------------------------------------------
   logic [DIST_BITS-1:0] dist_in;
   logic                 inside_in;
   logic                 inside_ff;

   assign dist_in   = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
   assign inside_in = CMP_BITS'(dist_in) < CMP_BITS'(radius_sq_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         inside_ff <= inside_in;
      end
   end

   // ------------------------------------------------------------------
   // list bookkeeping: capacity check, slot assignment, count update
   // ------------------------------------------------------------------
   logic [CB:0]  count_ff;
   logic [CB:0]  count_in;
   logic [CB:0]  cap;
   logic         full;
   logic         keep;
   logic         push;
   result_type   result_in;

   // capacity above the slot range saturates at the full range
   assign cap  = (max_sel_ff > FULL_CAP) ? FULL_CAP : max_sel_ff;
   assign full = (count_ff >= cap);
   assign keep = !full && inside_ff;
   assign push = enable && vld_ff[PIPE-1];

   always_comb begin
      result_in.keep       = keep;
      result_in.slot       = keep ? count_ff[CB-1:0] : '0;
      result_in.out_x      = px_ff[PIPE-1];
      result_in.out_y      = py_ff[PIPE-1];
      result_in.out_z      = pz_ff[PIPE-1];
      result_in.overflow   = full;
      result_in.end_of_set = last_ff[PIPE-1];
   end

   always_comb begin
      count_in = count_ff;
      if (push) begin
         if (last_ff[PIPE-1]) begin
            count_in = '0;
         end else if (keep) begin
            count_in = count_ff + (CB+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ------------------------------------------------------------------
   // output register and skid register
   // ------------------------------------------------------------------
   logic       out_vld_ff;
   result_type out_ff;
   result_type skid_ff;
   logic       pop;

   assign pop = out_vld_ff && rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         // pipe is frozen; drain the skid entry once the head leaves
         if (pop) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_vld_ff && !pop) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end else if (pop) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_vld_ff && !pop) begin
            skid_ff <= result_in;
         end else begin
            out_ff <= result_in;
         end
      end
   end

   assign rsp.valid      = out_vld_ff;
   assign rsp.keep       = out_ff.keep;
   assign rsp.slot       = out_ff.slot;
   assign rsp.out_x      = out_ff.out_x;
   assign rsp.out_y      = out_ff.out_y;
   assign rsp.out_z      = out_ff.out_z;
   assign rsp.overflow   = out_ff.overflow;
   assign rsp.end_of_set = out_ff.end_of_set;

endmodule

`default_nettype wire
